// ===== rtl/wgb_pkg.sv =====
// Shared constants, codes and types for the weighted 2-D grid binning block.
// No dependencies; compiled before the interfaces and modules.
`default_nettype none

package wgb_pkg;

   localparam int COORD_W    = 32;
   localparam int STEP_W     = 31;
   localparam int SUM_W      = 48;
   localparam int IDX_W      = 6;
   localparam int REQ_W      = 2;
   localparam int STAT_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int ALU_W      = 50;

   localparam int X_CELLS_DEF = 64;
   localparam int Y_CELLS_DEF = 64;

   // request codes
   localparam logic [REQ_W-1:0] REQ_DEPOSIT    = 2'd0;
   localparam logic [REQ_W-1:0] REQ_READ       = 2'd1;
   localparam logic [REQ_W-1:0] REQ_READ_CLEAR = 2'd2;

   // result status codes
   localparam logic [STAT_W-1:0] ST_DEPOSITED = 2'd0;
   localparam logic [STAT_W-1:0] ST_OUTSIDE   = 2'd1;
   localparam logic [STAT_W-1:0] ST_BEYOND    = 2'd2;
   localparam logic [STAT_W-1:0] ST_READ      = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_X_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_X_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_X_STEP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_Y_LOW  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_Y_HIGH = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_Y_STEP = 3'd5;

   // register reset values
   localparam logic signed [COORD_W-1:0] LOW_RST  = 32'sd0;
   localparam logic signed [COORD_W-1:0] HIGH_RST = 32'sd4194304;
   localparam logic [STEP_W-1:0]         STEP_RST = 31'd65536;

   localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   typedef struct packed {
      logic             sub;
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_op_type;

   typedef struct packed {
      logic [ALU_W-1:0] sum;
      logic             neg;
      logic             zero;
   } alu_res_type;

endpackage

`default_nettype wire

// ===== rtl/wgb_req_if.sv =====
// Request channel: valid/ready plus one deposit or read item.
// Depends on wgb_pkg.
`default_nettype none

interface wgb_req_if;
   logic                                valid;
   logic                                ready;
   logic [wgb_pkg::REQ_W-1:0]           req_type;
   logic signed [wgb_pkg::COORD_W-1:0]  x_coord;
   logic signed [wgb_pkg::COORD_W-1:0]  y_coord;
   logic signed [wgb_pkg::COORD_W-1:0]  add_x;
   logic signed [wgb_pkg::COORD_W-1:0]  add_y;
   logic [wgb_pkg::IDX_W-1:0]           read_col;
   logic [wgb_pkg::IDX_W-1:0]           read_row;

   modport source (output valid, req_type, x_coord, y_coord, add_x, add_y,
                   read_col, read_row, input ready);
   modport sink   (input valid, req_type, x_coord, y_coord, add_x, add_y,
                   read_col, read_row, output ready);
endinterface

`default_nettype wire

// ===== rtl/wgb_rsp_if.sv =====
// Result channel: valid/ready plus status, cell index and the two cell sums.
// Depends on wgb_pkg.
`default_nettype none

interface wgb_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [wgb_pkg::STAT_W-1:0]        status;
   logic [wgb_pkg::IDX_W-1:0]         cell_col;
   logic [wgb_pkg::IDX_W-1:0]         cell_row;
   logic signed [wgb_pkg::SUM_W-1:0]  total_x;
   logic signed [wgb_pkg::SUM_W-1:0]  total_y;

   modport source (output valid, status, cell_col, cell_row, total_x, total_y,
                   input ready);
   modport sink   (input valid, status, cell_col, cell_row, total_x, total_y,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/wgb_csr_if.sv =====
// Register write channel: valid/ready, register index and write data.
// Depends on wgb_pkg.
`default_nettype none

interface wgb_csr_if;
   logic                             valid;
   logic                             ready;
   logic [wgb_pkg::CSR_IDX_W-1:0]    reg_index;
   logic [wgb_pkg::COORD_W-1:0]      wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// ===== rtl/wgb_alu.sv =====
// Shared add/subtract unit with sign and zero flags.
// Depends on wgb_pkg (operand and result structs).
`default_nettype none

module wgb_alu (
   input  var wgb_pkg::alu_op_type  op,
   output wgb_pkg::alu_res_type     res
);

   logic [wgb_pkg::ALU_W-1:0] b_eff;
   logic [wgb_pkg::ALU_W-1:0] sum;

   always_comb begin
      b_eff    = op.sub ? ~op.b : op.b;
      sum      = op.a + b_eff + wgb_pkg::ALU_W'(op.sub);
      res.sum  = sum;
      res.neg  = sum[wgb_pkg::ALU_W-1];
      res.zero = (sum == '0);
   end

endmodule

`default_nettype wire

// ===== rtl/weighted_2d_grid_binning_top.sv =====
// Weighted 2-D grid binning: two saturating 48-bit accumulator grids.
// Deposit: a restoring divider finds the cell index on each axis, QW quotient bits,
// QW = clog2 of the larger grid dimension; it takes one quotient bit per cycle
// through the one shared 50-bit adder. Reads and out-of-window deposits skip it.
// Reset: sync, active high; then a zeroing pass clears all 2**(CW+RW) cells.
`default_nettype none

module weighted_2d_grid_binning_top #(
   parameter int X_CELLS = wgb_pkg::X_CELLS_DEF,
   parameter int Y_CELLS = wgb_pkg::Y_CELLS_DEF
) (
   input  wire       clock,
   input  wire       reset,
   wgb_req_if.sink   req_if,
   wgb_rsp_if.source rsp_if,
   wgb_csr_if.sink   csr_if
);

   // index widths: memory uses {row, col} concatenation, no multiply
   localparam int CW     = (X_CELLS > 1) ? $clog2(X_CELLS) : 1;
   localparam int RW     = (Y_CELLS > 1) ? $clog2(Y_CELLS) : 1;
   localparam int QW     = (CW > RW) ? CW : RW;           // quotient bits per axis
   localparam int IXW    = wgb_pkg::IDX_W;
   localparam int IW     = (QW + 1 > IXW) ? QW + 1 : IXW; // range-compare width
   localparam int ADDR_W = CW + RW;
   localparam int DIV_W  = wgb_pkg::STEP_W + QW;
   localparam int CNT_W  = $clog2(QW + 1);
   localparam int SW     = wgb_pkg::SUM_W;
   localparam int MEM_W  = 2 * SW;
   localparam int AW     = wgb_pkg::ALU_W;
   localparam int DW     = wgb_pkg::COORD_W;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_WIN, S_DIV, S_RD, S_LATCH, S_SUMX, S_SUMY, S_FIN
   } state_type;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   state_type                 state_ff, state_in;
   logic [ADDR_W-1:0]         clr_cnt_ff, clr_cnt_in;

   logic signed [DW-1:0]      x_low_ff, x_low_in, x_high_ff, x_high_in;
   logic signed [DW-1:0]      y_low_ff, y_low_in, y_high_ff, y_high_in;
   logic [wgb_pkg::STEP_W-1:0] x_step_ff, x_step_in, y_step_ff, y_step_in;

   logic [wgb_pkg::REQ_W-1:0] op_ff, op_in;
   logic signed [DW-1:0]      xc_ff, xc_in, yc_ff, yc_in, wx_ff, wx_in, wy_ff, wy_in;

   logic [1:0]                win_idx_ff, win_idx_in;
   logic [DW-1:0]             dx_ff, dx_in, dy_ff, dy_in;
   logic                      hi_x_ff, hi_x_in, hi_y_ff, hi_y_in;

   logic                      axis_ff, axis_in;
   logic [CNT_W-1:0]          div_cnt_ff, div_cnt_in;
   logic [DW-1:0]             rem_ff, rem_in;
   logic [DIV_W-1:0]          dvs_ff, dvs_in;
   logic [QW-1:0]             quo_ff, quo_in;
   logic [QW-1:0]             col_ff, col_in;
   logic                      strict_ff, strict_in;
   logic                      beyond_ff, beyond_in;
   logic [ADDR_W-1:0]         addr_ff, addr_in;

   // result waiting to be moved into the output register
   logic [wgb_pkg::STAT_W-1:0] pend_status_ff, pend_status_in;
   logic [IXW-1:0]            pend_col_ff, pend_col_in, pend_row_ff, pend_row_in;
   logic [SW-1:0]             pend_tx_ff, pend_tx_in, pend_ty_ff, pend_ty_in;
   logic                      pend_wr_ff, pend_wr_in;     // FIN writes the cell
   logic                      pend_zero_ff, pend_zero_in; // write is a clear

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [wgb_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [IXW-1:0]            rsp_col_ff, rsp_col_in, rsp_row_ff, rsp_row_in;
   logic [SW-1:0]             rsp_tx_ff, rsp_tx_in, rsp_ty_ff, rsp_ty_in;

   // grid store: {sum_y, sum_x} per cell, registered read
   logic [MEM_W-1:0]          grid_mem [2**ADDR_W];
   logic [MEM_W-1:0]          rd_data_ff;
   logic                      mem_we;
   logic [ADDR_W-1:0]         mem_waddr;
   logic [MEM_W-1:0]          mem_wdata;

   // ---------------------------------------------------------------------
   // Shared adder
   // ---------------------------------------------------------------------
   wgb_pkg::alu_op_type       alu_op;
   wgb_pkg::alu_res_type      alu_res;

   wgb_alu u_alu (
      .op  (alu_op),
      .res (alu_res)
   );

   logic                      req_fire;
   logic                      rsp_free;
   logic                      take;
   logic                      bey;
   logic                      rd_in_grid;
   logic [QW-1:0]             q_next;
   logic [SW-1:0]             rd_x, rd_y;
   logic [wgb_pkg::STEP_W-1:0] x_step_eff, y_step_eff;

   // clamp a 50-bit sum into the 48-bit signed range
   function automatic logic [SW-1:0] sat_sum(input logic [AW-1:0] v);
      logic [AW-SW:0] top;
      top = v[AW-1:SW-1];
      if ((&top) || !(|top)) begin
         return v[SW-1:0];
      end
      return v[AW-1] ? wgb_pkg::SUM_MIN : wgb_pkg::SUM_MAX;
   endfunction

   assign req_fire   = req_if.valid && req_if.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_if.ready;
   assign rd_x       = rd_data_ff[SW-1:0];
   assign rd_y       = rd_data_ff[MEM_W-1:SW];
   // a zero step behaves as the smallest step
   assign x_step_eff = (x_step_ff == '0) ? wgb_pkg::STEP_W'(1) : x_step_ff;
   assign y_step_eff = (y_step_ff == '0) ? wgb_pkg::STEP_W'(1) : y_step_ff;
   assign rd_in_grid = (IW'(req_if.read_col) < IW'(X_CELLS)) &&
                       (IW'(req_if.read_row) < IW'(Y_CELLS));

   // operand select for the shared adder
   always_comb begin
      alu_op.sub = 1'b1;
      alu_op.a   = '0;
      alu_op.b   = '0;
      case (state_ff)
         S_WIN: begin
            case (win_idx_ff)
               2'd0: begin
                  alu_op.a = AW'(xc_ff);
                  alu_op.b = AW'(x_low_ff);
               end
               2'd1: begin
                  alu_op.a = AW'(x_high_ff);
                  alu_op.b = AW'(xc_ff);
               end
               2'd2: begin
                  alu_op.a = AW'(yc_ff);
                  alu_op.b = AW'(y_low_ff);
               end
               default: begin
                  alu_op.a = AW'(y_high_ff);
                  alu_op.b = AW'(yc_ff);
               end
            endcase
         end
         S_DIV: begin
            alu_op.a = AW'(rem_ff);
            alu_op.b = AW'(dvs_ff);
         end
         S_SUMX: begin
            alu_op.sub = 1'b0;
            alu_op.a   = AW'($signed(rd_x));
            alu_op.b   = AW'(wx_ff);
         end
         S_SUMY: begin
            alu_op.sub = 1'b0;
            alu_op.a   = AW'($signed(rd_y));
            alu_op.b   = AW'(wy_ff);
         end
         default: begin
            alu_op.sub = 1'b1;
         end
      endcase
   end

   // on the high bound the index is floor((d-1)/step): same as a strict compare
   assign take   = strict_ff ? (!alu_res.neg && !alu_res.zero) : !alu_res.neg;
   assign q_next = QW'({quo_ff, take});

   // ---------------------------------------------------------------------
   // Sequencer next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      clr_cnt_in     = clr_cnt_ff;
      x_low_in       = x_low_ff;
      x_high_in      = x_high_ff;
      x_step_in      = x_step_ff;
      y_low_in       = y_low_ff;
      y_high_in      = y_high_ff;
      y_step_in      = y_step_ff;
      op_in          = op_ff;
      xc_in          = xc_ff;
      yc_in          = yc_ff;
      wx_in          = wx_ff;
      wy_in          = wy_ff;
      win_idx_in     = win_idx_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      hi_x_in        = hi_x_ff;
      hi_y_in        = hi_y_ff;
      axis_in        = axis_ff;
      div_cnt_in     = div_cnt_ff;
      rem_in         = rem_ff;
      dvs_in         = dvs_ff;
      quo_in         = quo_ff;
      col_in         = col_ff;
      strict_in      = strict_ff;
      beyond_in      = beyond_ff;
      addr_in        = addr_ff;
      pend_status_in = pend_status_ff;
      pend_col_in    = pend_col_ff;
      pend_row_in    = pend_row_ff;
      pend_tx_in     = pend_tx_ff;
      pend_ty_in     = pend_ty_ff;
      pend_wr_in     = pend_wr_ff;
      pend_zero_in   = pend_zero_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_col_in     = rsp_col_ff;
      rsp_row_in     = rsp_row_ff;
      rsp_tx_in      = rsp_tx_ff;
      rsp_ty_in      = rsp_ty_ff;
      bey            = beyond_ff;
      mem_we         = 1'b0;
      mem_waddr      = addr_ff;
      mem_wdata      = pend_zero_ff ? '0 : {pend_ty_ff, pend_tx_ff};

      // register writes are taken in any state
      if (csr_if.valid) begin
         case (csr_if.reg_index)
            wgb_pkg::REG_X_LOW:  x_low_in  = csr_if.wdata;
            wgb_pkg::REG_X_HIGH: x_high_in = csr_if.wdata;
            wgb_pkg::REG_X_STEP: x_step_in = csr_if.wdata[wgb_pkg::STEP_W-1:0];
            wgb_pkg::REG_Y_LOW:  y_low_in  = csr_if.wdata;
            wgb_pkg::REG_Y_HIGH: y_high_in = csr_if.wdata;
            wgb_pkg::REG_Y_STEP: y_step_in = csr_if.wdata[wgb_pkg::STEP_W-1:0];
            default: begin
               x_low_in = x_low_ff;
            end
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            // zero one cell per cycle after reset
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (&clr_cnt_ff) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_fire) begin
               op_in = req_if.req_type;
               xc_in = req_if.x_coord;
               yc_in = req_if.y_coord;
               wx_in = req_if.add_x;
               wy_in = req_if.add_y;
               if (req_if.req_type == wgb_pkg::REQ_DEPOSIT) begin
                  win_idx_in = 2'd0;
                  state_in   = S_WIN;
               end else begin
                  pend_col_in  = req_if.read_col;
                  pend_row_in  = req_if.read_row;
                  pend_zero_in = 1'b1;
                  if (rd_in_grid) begin
                     pend_status_in = wgb_pkg::ST_READ;
                     pend_wr_in     = (req_if.req_type == wgb_pkg::REQ_READ_CLEAR);
                     addr_in        = {RW'(req_if.read_row), CW'(req_if.read_col)};
                     state_in       = S_RD;
                  end else begin
                     pend_status_in = wgb_pkg::ST_BEYOND;
                     pend_wr_in     = 1'b0;
                     pend_tx_in     = '0;
                     pend_ty_in     = '0;
                     state_in       = S_FIN;
                  end
               end
            end
         end

         S_WIN: begin
            // four window compares; any negative difference drops the point
            if (alu_res.neg) begin
               pend_status_in = wgb_pkg::ST_OUTSIDE;
               pend_col_in    = '0;
               pend_row_in    = '0;
               pend_tx_in     = '0;
               pend_ty_in     = '0;
               pend_wr_in     = 1'b0;
               state_in       = S_FIN;
            end else begin
               win_idx_in = win_idx_ff + 2'd1;
               case (win_idx_ff)
                  2'd0: dx_in   = alu_res.sum[DW-1:0];
                  2'd1: hi_x_in = alu_res.zero;
                  2'd2: dy_in   = alu_res.sum[DW-1:0];
                  default: begin
                     hi_y_in    = alu_res.zero;
                     axis_in    = 1'b0;
                     div_cnt_in = CNT_W'(QW);
                     rem_in     = dx_ff;
                     dvs_in     = {x_step_eff, {QW{1'b0}}};
                     quo_in     = '0;
                     strict_in  = hi_x_ff;
                     beyond_in  = 1'b0;
                     state_in   = S_DIV;
                  end
               endcase
            end
         end

         S_DIV: begin
            dvs_in = dvs_ff >> 1;
            if (div_cnt_ff == CNT_W'(QW)) begin
               // first pass only checks for a quotient of 2**QW or more
               bey = beyond_ff || take;
            end else begin
               quo_in = q_next;
               if (take) begin
                  rem_in = alu_res.sum[DW-1:0];
               end
            end
            beyond_in  = bey;
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == '0) begin
               if (!axis_ff) begin
                  col_in     = q_next;
                  beyond_in  = bey || (IW'(q_next) >= IW'(X_CELLS));
                  axis_in    = 1'b1;
                  div_cnt_in = CNT_W'(QW);
                  rem_in     = dy_ff;
                  dvs_in     = {y_step_eff, {QW{1'b0}}};
                  quo_in     = '0;
                  strict_in  = hi_y_ff;
               end else if (bey || (IW'(q_next) >= IW'(Y_CELLS))) begin
                  pend_status_in = wgb_pkg::ST_BEYOND;
                  pend_col_in    = '0;
                  pend_row_in    = '0;
                  pend_tx_in     = '0;
                  pend_ty_in     = '0;
                  pend_wr_in     = 1'b0;
                  state_in       = S_FIN;
               end else begin
                  pend_status_in = wgb_pkg::ST_DEPOSITED;
                  pend_col_in    = IXW'(col_ff);
                  pend_row_in    = IXW'(q_next);
                  pend_wr_in     = 1'b1;
                  pend_zero_in   = 1'b0;
                  addr_in        = {RW'(q_next), CW'(col_ff)};
                  state_in       = S_RD;
               end
            end
         end

         S_RD: begin
            state_in = (op_ff == wgb_pkg::REQ_DEPOSIT) ? S_SUMX : S_LATCH;
         end

         S_LATCH: begin
            pend_tx_in = rd_x;
            pend_ty_in = rd_y;
            state_in   = S_FIN;
         end

         S_SUMX: begin
            pend_tx_in = sat_sum(alu_res.sum);
            state_in   = S_SUMY;
         end

         S_SUMY: begin
            pend_ty_in = sat_sum(alu_res.sum);
            state_in   = S_FIN;
         end

         S_FIN: begin
            // cell update and result load happen together
            if (rsp_free) begin
               mem_we        = pend_wr_ff;
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_col_in    = pend_col_ff;
               rsp_row_in    = pend_row_ff;
               rsp_tx_in     = pend_tx_ff;
               rsp_ty_in     = pend_ty_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         x_low_ff     <= wgb_pkg::LOW_RST;
         x_high_ff    <= wgb_pkg::HIGH_RST;
         x_step_ff    <= wgb_pkg::STEP_RST;
         y_low_ff     <= wgb_pkg::LOW_RST;
         y_high_ff    <= wgb_pkg::HIGH_RST;
         y_step_ff    <= wgb_pkg::STEP_RST;
      end else begin
         state_ff       <= state_in;
         clr_cnt_ff     <= clr_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         x_low_ff       <= x_low_in;
         x_high_ff      <= x_high_in;
         x_step_ff      <= x_step_in;
         y_low_ff       <= y_low_in;
         y_high_ff      <= y_high_in;
         y_step_ff      <= y_step_in;
         op_ff          <= op_in;
         xc_ff          <= xc_in;
         yc_ff          <= yc_in;
         wx_ff          <= wx_in;
         wy_ff          <= wy_in;
         win_idx_ff     <= win_idx_in;
         dx_ff          <= dx_in;
         dy_ff          <= dy_in;
         hi_x_ff        <= hi_x_in;
         hi_y_ff        <= hi_y_in;
         axis_ff        <= axis_in;
         div_cnt_ff     <= div_cnt_in;
         rem_ff         <= rem_in;
         dvs_ff         <= dvs_in;
         quo_ff         <= quo_in;
         col_ff         <= col_in;
         strict_ff      <= strict_in;
         beyond_ff      <= beyond_in;
         addr_ff        <= addr_in;
         pend_status_ff <= pend_status_in;
         pend_col_ff    <= pend_col_in;
         pend_row_ff    <= pend_row_in;
         pend_tx_ff     <= pend_tx_in;
         pend_ty_ff     <= pend_ty_in;
         pend_wr_ff     <= pend_wr_in;
         pend_zero_ff   <= pend_zero_in;
         rsp_status_ff  <= rsp_status_in;
         rsp_col_ff     <= rsp_col_in;
         rsp_row_ff     <= rsp_row_in;
         rsp_tx_ff      <= rsp_tx_in;
         rsp_ty_ff      <= rsp_ty_in;
      end
   end

   // grid store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= grid_mem[addr_ff];
   end

   // ---------------------------------------------------------------------
   // Ports
   // ---------------------------------------------------------------------
   assign req_if.ready    = (state_ff == S_IDLE);
   assign csr_if.ready    = 1'b1;
   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.status   = rsp_status_ff;
   assign rsp_if.cell_col = rsp_col_ff;
   assign rsp_if.cell_row = rsp_row_ff;
   assign rsp_if.total_x  = rsp_tx_ff;
   assign rsp_if.total_y  = rsp_ty_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // one item at a time: a request transfer always makes the block busy
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_if.ready)
      else $error("request taken while previous item in flight");

   // a new result appears only out of the finish step
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_if.valid) |-> $past(state_ff == S_FIN))
      else $error("result loaded outside finish step");

   // dropped points carry all-zero cell and sums
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status == wgb_pkg::ST_OUTSIDE) |->
         (rsp_if.cell_col == '0 && rsp_if.cell_row == '0 &&
          rsp_if.total_x == '0 && rsp_if.total_y == '0))
      else $error("outside-window result has nonzero fields");

endmodule

`default_nettype wire

// ===== bench/tb_weighted_2d_grid_binning_top.sv =====
// Self-checking bench for weighted_2d_grid_binning_top: deposits, reads and
// clears are predicted in-bench and each result transfer is checked in order.
// Depends on wgb_pkg, wgb_req_if, wgb_rsp_if, wgb_csr_if and the block itself.
`timescale 1ns / 1ps

module tb_weighted_2d_grid_binning_top;

   localparam int HALF_PERIOD     = 6;
   localparam int RESET_CYCLES    = 3;
   localparam int GRID_COLS       = wgb_pkg::X_CELLS_DEF;
   localparam int GRID_ROWS       = wgb_pkg::Y_CELLS_DEF;
   localparam int IDLE_MAX        = 4;
   // margin after the results drain, before register writes
   localparam int SETTLE_CYCLES   = 30;
   // the reset zeroing pass and the long hold-off fit well inside this
   localparam int STALL_LIMIT     = 20000;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int PHASES          = 5;
   localparam int PHASE_ITEMS     = 100;
   localparam int PRESSURE_ITEMS  = 40;

   // request code 3 has no name in the package; the block treats it as a read
   localparam logic [wgb_pkg::REQ_W-1:0] REQ_SPARE = 2'd3;

   typedef struct {
      logic [wgb_pkg::REQ_W-1:0]          kind;
      logic signed [wgb_pkg::COORD_W-1:0] x;
      logic signed [wgb_pkg::COORD_W-1:0] y;
      logic signed [wgb_pkg::COORD_W-1:0] wx;
      logic signed [wgb_pkg::COORD_W-1:0] wy;
      logic [wgb_pkg::IDX_W-1:0]          col;
      logic [wgb_pkg::IDX_W-1:0]          row;
   } bin_req_type;

   typedef struct {
      logic [wgb_pkg::STAT_W-1:0]       status;
      logic [wgb_pkg::IDX_W-1:0]        col;
      logic [wgb_pkg::IDX_W-1:0]        row;
      logic signed [wgb_pkg::SUM_W-1:0] tx;
      logic signed [wgb_pkg::SUM_W-1:0] ty;
   } bin_rsp_type;

   logic clock = 1'b0;
   logic reset;

   wgb_req_if req_bus ();
   wgb_rsp_if rsp_bus ();
   wgb_csr_if csr_bus ();

   weighted_2d_grid_binning_top #(
      .X_CELLS(GRID_COLS),
      .Y_CELLS(GRID_ROWS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_bus),
      .rsp_if(rsp_bus),
      .csr_if(csr_bus)
   );

   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow copy of the window registers and the two accumulator grids
   // ---------------------------------------------------------------------
   logic signed [wgb_pkg::COORD_W-1:0] win_x_low, win_x_high, win_y_low, win_y_high;
   logic [wgb_pkg::STEP_W-1:0]         cell_w, cell_h;
   logic signed [wgb_pkg::SUM_W-1:0]   sum_x_grid [0:GRID_COLS*GRID_ROWS-1];
   logic signed [wgb_pkg::SUM_W-1:0]   sum_y_grid [0:GRID_COLS*GRID_ROWS-1];

   bin_rsp_type cell_results_due [$];   // expected results, oldest first
   int          fail_count = 0;
   bit          no_idle = 1'b0;         // both sides run back to back when set
   bit          rsp_hold_pending = 1'b0;
   logic [wgb_pkg::IDX_W-1:0] last_hit_col = '0, last_hit_row = '0;

   function automatic void clear_shadow();
      win_x_low  = wgb_pkg::LOW_RST;
      win_x_high = wgb_pkg::HIGH_RST;
      cell_w     = wgb_pkg::STEP_RST;
      win_y_low  = wgb_pkg::LOW_RST;
      win_y_high = wgb_pkg::HIGH_RST;
      cell_h     = wgb_pkg::STEP_RST;
      for (int k = 0; k < GRID_COLS*GRID_ROWS; k++) begin
         sum_x_grid[k] = '0;
         sum_y_grid[k] = '0;
      end
   endfunction

   function automatic void apply_register(logic [wgb_pkg::CSR_IDX_W-1:0] idx,
                                          logic [wgb_pkg::COORD_W-1:0] data);
      case (idx)
         wgb_pkg::REG_X_LOW:  win_x_low  = data;
         wgb_pkg::REG_X_HIGH: win_x_high = data;
         wgb_pkg::REG_X_STEP: cell_w     = data[wgb_pkg::STEP_W-1:0];
         wgb_pkg::REG_Y_LOW:  win_y_low  = data;
         wgb_pkg::REG_Y_HIGH: win_y_high = data;
         wgb_pkg::REG_Y_STEP: cell_h     = data[wgb_pkg::STEP_W-1:0];
         default: ;
      endcase
   endfunction

   // floor((c - lo) / step); a point sitting on the upper bound folds into the
   // last covered cell. A step of zero behaves as one LSB.
   function automatic longint axis_cell(longint c, longint lo, longint hi, longint step);
      longint d;
      d = c - lo;
      if (step == 0) step = 1;
      if (c == hi) return (d == 0) ? 0 : (d - 1) / step;
      return d / step;
   endfunction

   function automatic logic signed [wgb_pkg::SUM_W-1:0] sat_add(
         logic signed [wgb_pkg::SUM_W-1:0] acc, logic signed [wgb_pkg::COORD_W-1:0] w);
      longint s;
      s = longint'(acc) + longint'(w);
      if (s > longint'($signed(wgb_pkg::SUM_MAX))) return wgb_pkg::SUM_MAX;
      if (s < longint'($signed(wgb_pkg::SUM_MIN))) return wgb_pkg::SUM_MIN;
      return s[wgb_pkg::SUM_W-1:0];
   endfunction

   // Applies one request to the shadow grids and returns the result it gives.
   function automatic bin_rsp_type bin_and_accumulate(bin_req_type r);
      bin_rsp_type res;
      longint      xc, yc, col, row;
      int          k;
      res.status = wgb_pkg::ST_OUTSIDE;
      res.col    = '0;
      res.row    = '0;
      res.tx     = '0;
      res.ty     = '0;
      if (r.kind == wgb_pkg::REQ_DEPOSIT) begin
         xc = longint'(r.x);
         yc = longint'(r.y);
         if (xc < longint'(win_x_low) || xc > longint'(win_x_high) ||
             yc < longint'(win_y_low) || yc > longint'(win_y_high)) begin
            res.status = wgb_pkg::ST_OUTSIDE;
         end else begin
            col = axis_cell(xc, win_x_low, win_x_high, longint'(cell_w));
            row = axis_cell(yc, win_y_low, win_y_high, longint'(cell_h));
            if (col >= GRID_COLS || row >= GRID_ROWS) begin
               res.status = wgb_pkg::ST_BEYOND;
            end else begin
               k = int'(row) * GRID_COLS + int'(col);
               sum_x_grid[k] = sat_add(sum_x_grid[k], r.wx);
               sum_y_grid[k] = sat_add(sum_y_grid[k], r.wy);
               res.status   = wgb_pkg::ST_DEPOSITED;
               res.col      = col[wgb_pkg::IDX_W-1:0];
               res.row      = row[wgb_pkg::IDX_W-1:0];
               res.tx       = sum_x_grid[k];
               res.ty       = sum_y_grid[k];
               last_hit_col = res.col;
               last_hit_row = res.row;
            end
         end
      end else begin
         res.col = r.col;
         res.row = r.row;
         if (r.col >= GRID_COLS || r.row >= GRID_ROWS) begin
            res.status = wgb_pkg::ST_BEYOND;
         end else begin
            k = int'(r.row) * GRID_COLS + int'(r.col);
            res.status = wgb_pkg::ST_READ;
            res.tx     = sum_x_grid[k];
            res.ty     = sum_y_grid[k];
            if (r.kind == wgb_pkg::REQ_READ_CLEAR) begin
               sum_x_grid[k] = '0;
               sum_y_grid[k] = '0;
            end
         end
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Request builders
   // ---------------------------------------------------------------------
   function automatic bin_req_type deposit_req(logic signed [wgb_pkg::COORD_W-1:0] x, y,
                                               wx, wy);
      bin_req_type r;
      r.kind = wgb_pkg::REQ_DEPOSIT;
      r.x    = x;
      r.y    = y;
      r.wx   = wx;
      r.wy   = wy;
      r.col  = wgb_pkg::IDX_W'($urandom);   // ignored on a deposit; bits still move
      r.row  = wgb_pkg::IDX_W'($urandom);
      return r;
   endfunction

   function automatic bin_req_type read_req(logic [wgb_pkg::REQ_W-1:0] kind,
                                            logic [wgb_pkg::IDX_W-1:0] col, row);
      bin_req_type r;
      r.kind = kind;
      r.x    = $urandom;
      r.y    = $urandom;
      r.wx   = $urandom;
      r.wy   = $urandom;
      r.col  = col;
      r.row  = row;
      return r;
   endfunction

   function automatic logic signed [wgb_pkg::COORD_W-1:0] window_point(longint lo,
                                                                      longint hi);
      longint span;
      if (hi < lo) return $urandom;
      span = hi - lo;
      case ($urandom_range(0, 7))
         0:       return lo[wgb_pkg::COORD_W-1:0];
         1:       return hi[wgb_pkg::COORD_W-1:0];
         default: return 32'(lo + longint'($urandom_range(0, 32'(span))));
      endcase
   endfunction

   function automatic logic signed [wgb_pkg::COORD_W-1:0] random_weight();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return $urandom_range(0, 2097152) - 1048576;
   endfunction

   // Mostly in-window deposits; the rest is off-window noise and reads. Each read
   // aims at the cell hit last with even odds, but for one plain-read case that never does.
   function automatic bin_req_type random_request();
      int                        sel;
      logic [wgb_pkg::IDX_W-1:0] c, rw;
      sel = $urandom_range(0, 19);
      if ($urandom_range(0, 1) == 0) begin
         c  = last_hit_col;
         rw = last_hit_row;
      end else begin
         c  = wgb_pkg::IDX_W'($urandom);
         rw = wgb_pkg::IDX_W'($urandom);
      end
      if (sel < 12)
         return deposit_req(window_point(win_x_low, win_x_high),
                            window_point(win_y_low, win_y_high),
                            random_weight(), random_weight());
      if (sel < 14)
         return deposit_req($urandom, $urandom, random_weight(), random_weight());
      if (sel < 17) return read_req(wgb_pkg::REQ_READ, c, rw);
      if (sel == 17) return read_req(wgb_pkg::REQ_READ_CLEAR, c, rw);
      if (sel == 18) return read_req(REQ_SPARE, c, rw);
      return read_req(wgb_pkg::REQ_READ, wgb_pkg::IDX_W'($urandom),
                      wgb_pkg::IDX_W'($urandom));
   endfunction

   // ---------------------------------------------------------------------
   // Channel drivers
   // ---------------------------------------------------------------------
   // valid stays high after a transfer; it only drops when a gap is drawn or results drain
   task automatic send_request(bin_req_type r);
      int          gap;
      bin_rsp_type due;
      gap = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= r.kind;
      req_bus.x_coord  <= r.x;
      req_bus.y_coord  <= r.y;
      req_bus.add_x    <= r.wx;
      req_bus.add_y    <= r.wy;
      req_bus.read_col <= r.col;
      req_bus.read_row <= r.row;
      do @(posedge clock); while (!req_bus.ready);
      due = bin_and_accumulate(r);
      cell_results_due.push_back(due);
   endtask

   // Block goes idle: no request offered and every result back.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (cell_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [wgb_pkg::CSR_IDX_W-1:0] idx,
                            logic [wgb_pkg::COORD_W-1:0] data);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= idx;
      csr_bus.wdata     <= data;
      do @(posedge clock); while (!csr_bus.ready);
      apply_register(idx, data);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_window(logic [wgb_pkg::COORD_W-1:0] xl, xh, xs, yl, yh, ys);
      drain_results();
      csr_write(wgb_pkg::REG_X_LOW, xl);
      csr_write(wgb_pkg::REG_X_HIGH, xh);
      csr_write(wgb_pkg::REG_X_STEP, xs);
      csr_write(wgb_pkg::REG_Y_LOW, yl);
      csr_write(wgb_pkg::REG_Y_HIGH, yh);
      csr_write(wgb_pkg::REG_Y_STEP, ys);
   endtask

   // Sensible window: 1..70 cells per axis (so some land past the grid),
   // the upper bound landing anywhere inside the last cell.
   task automatic random_window();
      longint xl, xs, yl, ys;
      int     nx, ny;
      xl = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
      yl = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
      xs = $urandom_range(1, 1 << 17);
      ys = $urandom_range(1, 1 << 17);
      nx = $urandom_range(1, 70);
      ny = $urandom_range(1, 70);
      set_window(32'(xl), 32'(xl + nx * xs - $urandom_range(0, 32'(xs - 1))), 32'(xs),
                 32'(yl), 32'(yl + ny * ys - $urandom_range(0, 32'(ys - 1))), 32'(ys));
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stalls, plus one long hold-off when requested
   // ---------------------------------------------------------------------
   initial begin : result_sink
      int stall;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_pending) begin
            rsp_hold_pending = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end
         stall = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         fail_count++;
         $error("%s: expected %0h, got %0h", name, want, got);
      end
   endfunction

   // Each result transfer is matched against the oldest expectation.
   always @(posedge clock) begin : result_check
      bin_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (cell_results_due.size() == 0) begin
            fail_count++;
            $error("result transfer with no expected result pending");
         end else begin
            want = cell_results_due.pop_front();
            compare_field("status", 64'(want.status), 64'(rsp_bus.status));
            compare_field("cell_col", 64'(want.col), 64'(rsp_bus.cell_col));
            compare_field("cell_row", 64'(want.row), 64'(rsp_bus.cell_row));
            compare_field("total_x", 64'(want.tx), 64'(rsp_bus.total_x));
            compare_field("total_y", 64'(want.ty), 64'(rsp_bus.total_y));
         end
      end
   end

   // Watchdog: any stretch without a single transfer on any channel.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Reset window is [0, 64.0] with unit cells on both axes.
   task automatic test_reset_window();
      send_request(deposit_req(0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000));
      send_request(deposit_req(0, 0, 1, -1));
      // on the upper bound: folds into cell 63, not 64
      send_request(deposit_req(32'sd4194304, 32'sd4194304, -5, 7));
      send_request(deposit_req(32'sd4194303, 32'sd65535, 3, 3));
      send_request(deposit_req(32'sd65536, 32'sd131072, 9, 9));
      // outside the window: dropped, later items unaffected
      send_request(deposit_req(32'sd4194305, 0, 1, 1));
      send_request(deposit_req(-1, 0, 1, 1));
      send_request(deposit_req(0, 32'sh8000_0000, 1, 1));
      send_request(deposit_req(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1, 1));
      send_request(read_req(wgb_pkg::REQ_READ, 0, 0));
      send_request(read_req(wgb_pkg::REQ_READ_CLEAR, 0, 0));
      send_request(read_req(wgb_pkg::REQ_READ, 0, 0));
      send_request(read_req(REQ_SPARE, 63, 63));
      send_request(read_req(wgb_pkg::REQ_READ_CLEAR, 63, 63));
      send_request(read_req(wgb_pkg::REQ_READ, 63, 63));
      send_request(read_req(wgb_pkg::REQ_READ, 5, 40));
      send_request(read_req(wgb_pkg::REQ_READ, 63, 0));
   endtask

   task automatic test_window_extremes();
      // full 32-bit span; largest x step, y step register zero (acts as 1)
      // with bit 31 of the write data set, which the register drops
      set_window(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(deposit_req(32'sh8000_0000, 32'sh8000_0000, 4, 4));
      send_request(deposit_req(32'sh7FFF_FFFF, 32'sh8000_003F, 5, 5));
      send_request(deposit_req(0, 32'sh8000_0040, 6, 6));          // row 64: beyond
      send_request(deposit_req(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 7, 7));
      send_request(read_req(wgb_pkg::REQ_READ, 2, 63));
      // inverted x window: nothing is inside
      set_window(32'h7FFF_FFFF, 32'h8000_0000, 32'd65536, 0, 32'd4194304, 32'd1);
      send_request(deposit_req(0, 0, 1, 1));
      send_request(deposit_req(32'sh8000_0000, 0, 1, 1));
      // zero-width x window, y window centered on zero
      set_window(32'd123456, 32'd123456, 32'd1, -32'sd196608, 32'sd196608, 32'd65536);
      send_request(deposit_req(32'sd123456, 32'sd196608, 11, -11));
      send_request(deposit_req(32'sd123457, 0, 1, 1));
      send_request(deposit_req(32'sd123456, -32'sd196608, 2, 2));
      send_request(read_req(wgb_pkg::REQ_READ, 0, 5));
      // one-LSB x cells: the window is far wider than the grid
      set_window(0, 32'd1000, 32'd1, 0, 32'd1000, 32'd16);
      send_request(deposit_req(32'sd63, 32'sd1000, 8, 8));
      send_request(deposit_req(32'sd64, 0, 8, 8));
      send_request(deposit_req(32'sd1000, 32'sd1000, 8, 8));
   endtask

   // Several windows; one with fully random register contents, one phase
   // without any idling on either side.
   task automatic test_random_traffic();
      for (int p = 0; p < PHASES; p++) begin
         if (p == 2)
            set_window($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         else
            random_window();
         no_idle = (p == 3);
         for (int i = 0; i < PHASE_ITEMS; i++) send_request(random_request());
         no_idle = 1'b0;
      end
   endtask

   // Result side holds off for a long stretch while requests keep coming,
   // so the block backs up and stalls its request side.
   task automatic test_backpressure();
      drain_results();
      rsp_hold_pending = 1'b1;
      for (int i = 0; i < PRESSURE_ITEMS; i++) send_request(random_request());
   endtask

   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.req_type = wgb_pkg::REQ_DEPOSIT;
      req_bus.x_coord  = '0;
      req_bus.y_coord  = '0;
      req_bus.add_x    = '0;
      req_bus.add_y    = '0;
      req_bus.read_col = '0;
      req_bus.read_row = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.reg_index = wgb_pkg::REG_X_LOW;
      csr_bus.wdata     = '0;
      clear_shadow();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_window();
      test_window_extremes();
      test_random_traffic();
      test_backpressure();

      drain_results();
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== weighted_2d_grid_binning_top.f =====
rtl/wgb_pkg.sv
rtl/wgb_req_if.sv
rtl/wgb_rsp_if.sv
rtl/wgb_csr_if.sv
rtl/wgb_alu.sv
rtl/weighted_2d_grid_binning_top.sv
bench/tb_weighted_2d_grid_binning_top.sv
